// ===== rtl/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg
// shared widths, codes and the configuration register bundle of the battery
// level monitor
// ----------------------------------------------------------------------------
package blm_pkg;

	// converter resolution and derived widths
	localparam int ADC_BITS   = 12;
	localparam int PCT_W      = 7;
	localparam int NUM_W      = ADC_BITS + PCT_W;   // magnitude of (level-empty)*100
	localparam int STATE_W    = 3;
	localparam int ALERT_W    = 2;
	localparam int INTERVAL_W = 16;
	localparam int ELAPSED_W  = INTERVAL_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (INTERVAL_W > ADC_BITS) ? INTERVAL_W : ADC_BITS;

	localparam int PCT_MAX = 100;

	// reset values of the configuration registers
	localparam int INTERVAL_RST = 1000;
	localparam int EMPTY_RST    = 0;
	localparam int FULL_RST     = 4095;
	localparam int CHARGE_RST   = 4000;
	localparam int FULLTH_RST   = 3800;
	localparam int CRIT_RST     = 2400;
	localparam int LOWTH_RST    = 2800;

	typedef enum logic [STATE_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_CHARGING = 3'd2,
		ST_CRITICAL = 3'd3,
		ST_LOW      = 3'd4,
		ST_UNKNOWN  = 3'd5
	} batt_state_t;

	typedef enum logic [ALERT_W-1:0] {
		AL_NONE     = 2'd0,
		AL_CHARGING = 2'd1,
		AL_CRITICAL = 2'd2,
		AL_LOW      = 2'd3
	} alert_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL = 3'd0,
		REG_EMPTY    = 3'd1,
		REG_FULL     = 3'd2,
		REG_CHARGE   = 3'd3,
		REG_FULLTH   = 3'd4,
		REG_CRIT     = 3'd5,
		REG_LOWTH    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] interval_ms;
		logic [ADC_BITS-1:0]   empty_level;
		logic [ADC_BITS-1:0]   full_level;
		logic [ADC_BITS-1:0]   charging_threshold;
		logic [ADC_BITS-1:0]   full_threshold;
		logic [ADC_BITS-1:0]   critical_threshold;
		logic [ADC_BITS-1:0]   low_threshold;
	} cfg_t;

endpackage

// ===== rtl/battery_level_monitor.sv =====
// ----------------------------------------------------------------------------
// battery_level_monitor
// tick-driven battery sampler with charge percentage and state alerts
// ----------------------------------------------------------------------------
// usage:
//   each transfer on the input channel (in_valid / in_stall) is one 1 ms tick
//   carrying the current raw converter reading. every tick yields exactly one
//   transfer on the output channel (out_valid / out_stall).
//   the first tick after reset takes a sample; afterwards a sample is taken
//   once the tick count since the last one exceeds interval_ms.
//   a sample runs a serial restoring divider, one quotient bit per cycle,
//   for the percentage. a tick without a sample, or a sample whose
//   percentage is zero by sign, passes the divider by.
//   in_stall is high while an item is in work; one item at a time.
//   a finished result sits in the output register; a new tick is taken while
//   it waits, but its result is written only once the old one has left.
//   while out_stall is high the output fields hold steady.
//   reset (arst_n low) restores the register defaults, clears the tick count,
//   marks the state unknown and empties the output register.
//   configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
//   and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module battery_level_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_wr_en,
	input  logic [blm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [blm_pkg::CFG_DATA_W-1:0]   cfg_data,
	// tick input
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [blm_pkg::ADC_BITS-1:0]     raw_reading,
	// result output
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             sampled,
	output logic [blm_pkg::ADC_BITS-1:0]     level,
	output logic [blm_pkg::PCT_W-1:0]        percent,
	output logic [blm_pkg::STATE_W-1:0]      battery_state,
	output logic [blm_pkg::STATE_W-1:0]      prior_state,
	output logic                             changed,
	output logic [blm_pkg::ALERT_W-1:0]      alert
);

	localparam int ADC_W = blm_pkg::ADC_BITS;
	localparam int NUM_W = blm_pkg::NUM_W;
	localparam int PCT_W = blm_pkg::PCT_W;
	localparam int EL_W  = blm_pkg::ELAPSED_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_FIN
	} seq_state_t;

	blm_pkg::cfg_t cfg;

	// sequencer and held state
	seq_state_t               state_q;
	logic [EL_W-1:0]          elapsed_q;
	logic                     first_q;
	logic                     take_q;
	logic [ADC_W-1:0]         reading_q;
	logic [PCT_W-1:0]         pct_q;
	logic [ADC_W-1:0]         held_level_q;
	logic [PCT_W-1:0]         held_pct_q;
	blm_pkg::batt_state_t     cur_state_q;
	blm_pkg::batt_state_t     prev_state_q;

	// output register
	logic                     out_valid_q;
	logic                     sampled_q;
	logic [ADC_W-1:0]         level_q;
	logic [PCT_W-1:0]         percent_q;
	blm_pkg::batt_state_t     batt_q;
	blm_pkg::batt_state_t     prior_q;
	logic                     changed_q;
	blm_pkg::alert_t          alert_q;

	logic                     in_xfer;
	logic                     out_free;
	logic [EL_W-1:0]          elapsed_inc;
	logic                     take;

	logic [ADC_W:0]           num_diff;
	logic [ADC_W:0]           den_diff;
	logic [ADC_W-1:0]         num_mag;
	logic [ADC_W-1:0]         den_mag;
	logic                     pct_zero;
	logic [NUM_W-1:0]         dividend;

	logic                     div_start;
	logic                     div_done;
	logic [NUM_W-1:0]         quotient;

	blm_pkg::batt_state_t     next_class;
	blm_pkg::alert_t          next_alert;
	logic                     state_diff;

	blm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	// result slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	// tick counter saturates at its maximum
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + EL_W'(1);
	assign take        = first_q || (elapsed_inc > {1'b0, cfg.interval_ms});

	// percentage operands as sign and magnitude
	assign num_diff = {1'b0, reading_q} - {1'b0, cfg.empty_level};
	assign den_diff = {1'b0, cfg.full_level} - {1'b0, cfg.empty_level};
	assign num_mag  = num_diff[ADC_W] ? ADC_W'(-num_diff) : num_diff[ADC_W-1:0];
	assign den_mag  = den_diff[ADC_W] ? ADC_W'(-den_diff) : den_diff[ADC_W-1:0];
	// zero divisor, zero numerator or a negative quotient all clamp to zero
	assign pct_zero = (den_diff == '0) || (num_diff == '0)
		|| (num_diff[ADC_W] != den_diff[ADC_W]);
	assign dividend = NUM_W'(num_mag) * NUM_W'(blm_pkg::PCT_MAX);

	assign div_start = (state_q == S_PREP) && !pct_zero;

	blm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den_mag),
		.done     (div_done),
		.quotient (quotient)
	);

	// threshold sort, fixed test order
	always_comb begin
		priority if (reading_q >= cfg.charging_threshold) begin
			next_class = blm_pkg::ST_CHARGING;
		end else if (reading_q >= cfg.full_threshold) begin
			next_class = blm_pkg::ST_FULL;
		end else if (reading_q <= cfg.critical_threshold) begin
			next_class = blm_pkg::ST_CRITICAL;
		end else if (reading_q <= cfg.low_threshold) begin
			next_class = blm_pkg::ST_LOW;
		end else begin
			next_class = blm_pkg::ST_OK;
		end
	end

	assign state_diff = (next_class != cur_state_q);

	always_comb begin
		unique case (next_class)
			blm_pkg::ST_CHARGING: next_alert = blm_pkg::AL_CHARGING;
			blm_pkg::ST_CRITICAL: next_alert = blm_pkg::AL_CRITICAL;
			blm_pkg::ST_LOW:      next_alert = blm_pkg::AL_LOW;
			default:              next_alert = blm_pkg::AL_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			elapsed_q    <= '0;
			first_q      <= 1'b1;
			take_q       <= 1'b0;
			held_level_q <= '0;
			held_pct_q   <= '0;
			cur_state_q  <= blm_pkg::ST_UNKNOWN;
			prev_state_q <= blm_pkg::ST_UNKNOWN;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						take_q    <= take;
						elapsed_q <= take ? '0 : elapsed_inc;
						if (take) begin
							first_q <= 1'b0;
							state_q <= S_PREP;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_PREP: begin
					if (pct_zero) begin
						pct_q   <= '0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						pct_q   <= (quotient > NUM_W'(blm_pkg::PCT_MAX))
							? PCT_W'(blm_pkg::PCT_MAX) : quotient[PCT_W-1:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						sampled_q   <= take_q;
						if (take_q) begin
							held_level_q <= reading_q;
							held_pct_q   <= pct_q;
							prev_state_q <= cur_state_q;
							cur_state_q  <= next_class;
							level_q      <= reading_q;
							percent_q    <= pct_q;
							batt_q       <= next_class;
							prior_q      <= cur_state_q;
							changed_q    <= state_diff;
							alert_q      <= state_diff ? next_alert : blm_pkg::AL_NONE;
						end else begin
							level_q      <= held_level_q;
							percent_q    <= held_pct_q;
							batt_q       <= cur_state_q;
							prior_q      <= prev_state_q;
							changed_q    <= 1'b0;
							alert_q      <= blm_pkg::AL_NONE;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// reading is captured on each input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			reading_q <= raw_reading;
		end
	end

	assign out_valid     = out_valid_q;
	assign sampled       = sampled_q;
	assign level         = level_q;
	assign percent       = percent_q;
	assign battery_state = batt_q;
	assign prior_state   = prior_q;
	assign changed       = changed_q;
	assign alert         = alert_q;

	// divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide step");

	// percentage never leaves its clamp range
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (percent_q <= PCT_W'(blm_pkg::PCT_MAX)))
		else $error("percent above clamp");

	// a tick without a sample reports no change and no alert
	a_no_sample_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !sampled_q) |-> (!changed_q && alert_q == blm_pkg::AL_NONE))
		else $error("change flagged on a tick without sample");

	// a flagged change really differs from the prior state
	a_change_differs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && changed_q) |-> (batt_q != prior_q))
		else $error("change flagged with equal states");

	// once sampled, the first-sample flag stays cleared
	a_first_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |=> !first_q)
		else $error("first-sample flag set again");

endmodule

// ===== rtl/blm_cfg.sv =====
// ----------------------------------------------------------------------------
// blm_cfg
// configuration register file, written through a plain index/data port
// ----------------------------------------------------------------------------
module blm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [blm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [blm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output blm_pkg::cfg_t                    cfg
);

	blm_pkg::cfg_t               cfg_q;
	logic [blm_pkg::ADC_BITS-1:0] wr_adc;

	assign wr_adc = cfg_data[blm_pkg::ADC_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ms        <= blm_pkg::INTERVAL_W'(blm_pkg::INTERVAL_RST);
			cfg_q.empty_level        <= blm_pkg::ADC_BITS'(blm_pkg::EMPTY_RST);
			cfg_q.full_level         <= blm_pkg::ADC_BITS'(blm_pkg::FULL_RST);
			cfg_q.charging_threshold <= blm_pkg::ADC_BITS'(blm_pkg::CHARGE_RST);
			cfg_q.full_threshold     <= blm_pkg::ADC_BITS'(blm_pkg::FULLTH_RST);
			cfg_q.critical_threshold <= blm_pkg::ADC_BITS'(blm_pkg::CRIT_RST);
			cfg_q.low_threshold      <= blm_pkg::ADC_BITS'(blm_pkg::LOWTH_RST);
		end else if (cfg_wr_en) begin
			unique case (blm_pkg::reg_idx_t'(cfg_index))
				blm_pkg::REG_INTERVAL: cfg_q.interval_ms <= cfg_data[blm_pkg::INTERVAL_W-1:0];
				blm_pkg::REG_EMPTY:    cfg_q.empty_level        <= wr_adc;
				blm_pkg::REG_FULL:     cfg_q.full_level         <= wr_adc;
				blm_pkg::REG_CHARGE:   cfg_q.charging_threshold <= wr_adc;
				blm_pkg::REG_FULLTH:   cfg_q.full_threshold     <= wr_adc;
				blm_pkg::REG_CRIT:     cfg_q.critical_threshold <= wr_adc;
				blm_pkg::REG_LOWTH:    cfg_q.low_threshold      <= wr_adc;
				default: ;             // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/blm_div.sv =====
// ----------------------------------------------------------------------------
// blm_div
// unsigned restoring divider, one quotient bit per cycle through a single
// shared subtract and compare
// ----------------------------------------------------------------------------
module blm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [blm_pkg::NUM_W-1:0]      dividend,
	input  logic [blm_pkg::ADC_BITS-1:0]   divisor,
	output logic                           done,
	output logic [blm_pkg::NUM_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(blm_pkg::NUM_W + 1);
	localparam int REM_W = blm_pkg::ADC_BITS;

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [blm_pkg::NUM_W-1:0]   dvd_q;
	logic [REM_W-1:0]            dvs_q;
	logic [REM_W-1:0]            rem_q;

	logic [REM_W:0]              rem_shift;
	logic [REM_W+1:0]            trial;
	logic                        borrow;

	// shift in next dividend bit, try subtracting the divisor
	assign rem_shift = {rem_q, dvd_q[blm_pkg::NUM_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, dvs_q};
	assign borrow    = trial[REM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(blm_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= borrow ? rem_shift[REM_W-1:0] : trial[REM_W-1:0];
			dvd_q <= {dvd_q[blm_pkg::NUM_W-2:0], ~borrow};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== tb/tb_battery_level_monitor.sv =====
// ----------------------------------------------------------------------------
// tb_battery_level_monitor
// self-checking bench for the tick-driven battery level monitor: every tick
// transfer is run through an in-bench copy of the sampler, percentage and
// state sorting, and each result transfer is compared field by field with
// the oldest predicted result. directed tests cover reset defaults, every
// state and alert, degenerate and reversed calibration spans, overlapping
// thresholds and a long interval; random phases follow with fresh
// register settings and random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_battery_level_monitor;

	localparam int IDLE_LIMIT    = 1000;  // cycles without any transfer
	localparam int SETTLE_CYCLES = 64;    // quiet time after the last result
	localparam int MAX_SHOWN     = 10;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_TICKS   = 55;
	localparam int LONG_INTERVAL = 40;
	localparam int GUARD_TICKS   = 100;

	// one result transfer as the monitor should present it
	typedef struct packed {
		logic                         sampled;
		logic [blm_pkg::ADC_BITS-1:0] level;
		logic [blm_pkg::PCT_W-1:0]    percent;
		blm_pkg::batt_state_t         state;
		blm_pkg::batt_state_t         prior;
		logic                         changed;
		blm_pkg::alert_t              alert;
	} tick_result_t;

	logic                           clk;
	logic                           arst_n      = 1'b0;
	logic                           cfg_wr_en   = 1'b0;
	logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [blm_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
	logic                           in_valid    = 1'b0;
	logic                           in_stall;
	logic [blm_pkg::ADC_BITS-1:0]   raw_reading = '0;
	logic                           out_valid;
	logic                           out_stall   = 1'b0;
	logic                           sampled;
	logic [blm_pkg::ADC_BITS-1:0]   level;
	logic [blm_pkg::PCT_W-1:0]      percent;
	logic [blm_pkg::STATE_W-1:0]    battery_state;
	logic [blm_pkg::STATE_W-1:0]    prior_state;
	logic                           changed;
	logic [blm_pkg::ALERT_W-1:0]    alert;

	// bench copy of the monitor: registers and sampler state
	blm_pkg::cfg_t                 cfg_model;
	logic [blm_pkg::ELAPSED_W-1:0] tick_count;
	logic                          first_due;
	logic [blm_pkg::ADC_BITS-1:0]  held_reading;
	logic [blm_pkg::PCT_W-1:0]     held_pct;
	blm_pkg::batt_state_t          now_state;
	blm_pkg::batt_state_t          old_state;
	bit                            last_sampled;

	tick_result_t tick_results_q[$];
	int           mismatches  = 0;
	int           idle_cycles = 0;
	bit           quiet       = 1'b0;  // no gaps on either channel while set

	battery_level_monitor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.raw_reading   (raw_reading),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sampled       (sampled),
		.level         (level),
		.percent       (percent),
		.battery_state (battery_state),
		.prior_state   (prior_state),
		.changed       (changed),
		.alert         (alert)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// (level - empty) * 100 / (full - empty), signed, truncated, clamped
	function automatic logic [blm_pkg::PCT_W-1:0] charge_percent(
			input logic [blm_pkg::ADC_BITS-1:0] lvl);
		int span;
		int q;
		span = int'(cfg_model.full_level) - int'(cfg_model.empty_level);
		if (span == 0)
			return '0;
		q = ((int'(lvl) - int'(cfg_model.empty_level)) * blm_pkg::PCT_MAX) / span;
		if (q < 0)
			q = 0;
		if (q > blm_pkg::PCT_MAX)
			q = blm_pkg::PCT_MAX;
		return q[blm_pkg::PCT_W-1:0];
	endfunction

	// fixed test order decides when thresholds overlap
	function automatic blm_pkg::batt_state_t sort_state(
			input logic [blm_pkg::ADC_BITS-1:0] lvl);
		if (lvl >= cfg_model.charging_threshold)
			return blm_pkg::ST_CHARGING;
		if (lvl >= cfg_model.full_threshold)
			return blm_pkg::ST_FULL;
		if (lvl <= cfg_model.critical_threshold)
			return blm_pkg::ST_CRITICAL;
		if (lvl <= cfg_model.low_threshold)
			return blm_pkg::ST_LOW;
		return blm_pkg::ST_OK;
	endfunction

	// advance the bench copy by one accepted tick and queue its result
	function automatic void battery_tick(input logic [blm_pkg::ADC_BITS-1:0] rd);
		tick_result_t r;
		bit           take;
		take = first_due;
		if (!first_due) begin
			// saturating tick count, sample once it exceeds the interval
			if (tick_count != '1)
				tick_count++;
			if (tick_count > {1'b0, cfg_model.interval_ms})
				take = 1'b1;
		end
		r.changed = 1'b0;
		r.alert   = blm_pkg::AL_NONE;
		if (take) begin
			first_due    = 1'b0;
			tick_count   = '0;
			held_reading = rd;
			held_pct     = charge_percent(rd);
			old_state    = now_state;
			now_state    = sort_state(rd);
			if (now_state != old_state) begin
				r.changed = 1'b1;
				case (now_state)
					blm_pkg::ST_CHARGING: r.alert = blm_pkg::AL_CHARGING;
					blm_pkg::ST_CRITICAL: r.alert = blm_pkg::AL_CRITICAL;
					blm_pkg::ST_LOW:      r.alert = blm_pkg::AL_LOW;
					default:              r.alert = blm_pkg::AL_NONE;
				endcase
			end
		end
		r.sampled    = take;
		r.level      = held_reading;
		r.percent    = held_pct;
		r.state      = now_state;
		r.prior      = old_state;
		last_sampled = take;
		tick_results_q.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 13);
	endfunction

	// one tick transfer; valid stays high afterwards so a zero gap runs
	// back to back without a low pulse
	task automatic send_tick(input logic [blm_pkg::ADC_BITS-1:0] rd);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		raw_reading <= rd;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		battery_tick(rd);
	endtask

	// stop sending and wait until every predicted result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (tick_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input blm_pkg::reg_idx_t idx,
			input logic [blm_pkg::CFG_DATA_W-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		// 12-bit registers keep only the converter width
		case (idx)
			blm_pkg::REG_INTERVAL:
				cfg_model.interval_ms        = d[blm_pkg::INTERVAL_W-1:0];
			blm_pkg::REG_EMPTY:
				cfg_model.empty_level        = d[blm_pkg::ADC_BITS-1:0];
			blm_pkg::REG_FULL:
				cfg_model.full_level         = d[blm_pkg::ADC_BITS-1:0];
			blm_pkg::REG_CHARGE:
				cfg_model.charging_threshold = d[blm_pkg::ADC_BITS-1:0];
			blm_pkg::REG_FULLTH:
				cfg_model.full_threshold     = d[blm_pkg::ADC_BITS-1:0];
			blm_pkg::REG_CRIT:
				cfg_model.critical_threshold = d[blm_pkg::ADC_BITS-1:0];
			blm_pkg::REG_LOWTH:
				cfg_model.low_threshold      = d[blm_pkg::ADC_BITS-1:0];
			default: ;
		endcase
	endtask

	// rewrite every register, only once the block has gone idle
	task automatic load_config(input logic [blm_pkg::CFG_DATA_W-1:0] iv, em, fu, ch, ft,
			cr, lo);
		drain_results();
		put_reg(blm_pkg::REG_INTERVAL, iv);
		put_reg(blm_pkg::REG_EMPTY, em);
		put_reg(blm_pkg::REG_FULL, fu);
		put_reg(blm_pkg::REG_CHARGE, ch);
		put_reg(blm_pkg::REG_FULLTH, ft);
		put_reg(blm_pkg::REG_CRIT, cr);
		put_reg(blm_pkg::REG_LOWTH, lo);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("mismatch in %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	task automatic check_tick_result();
		tick_result_t want;
		if (tick_results_q.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("result transfer with nothing expected: level %0d state %0d",
					level, battery_state);
			return;
		end
		want = tick_results_q.pop_front();
		check_field("sampled", 16'(want.sampled), 16'(sampled));
		check_field("level", 16'(want.level), 16'(level));
		check_field("percent", 16'(want.percent), 16'(percent));
		check_field("battery_state", 16'(want.state), 16'(battery_state));
		check_field("prior_state", 16'(want.prior), 16'(prior_state));
		check_field("changed", 16'(want.changed), 16'(changed));
		check_field("alert", 16'(want.alert), 16'(alert));
	endtask

	// receiving side: random stall per result, then take one transfer
	initial begin : result_sink
		int hold;
		forever begin
			hold = draw_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
			check_tick_result();
		end
	end

	// watchdog: too long without a transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset defaults: first tick samples, the long default interval holds
	task automatic test_reset_defaults();
		send_tick(12'd4095);
		send_tick(12'd100);
		send_tick(12'd2000);
	endtask

	// every tick samples; walk across each threshold edge
	task automatic test_threshold_sort();
		load_config(16'd0, 16'd0, 16'd4095, 16'd4000, 16'd3800, 16'd2400, 16'd2800);
		send_tick(12'd4000);  // still charging, no change
		send_tick(12'd3999);  // full, change without alert
		send_tick(12'd3800);
		send_tick(12'd3799);  // ok
		send_tick(12'd2801);
		send_tick(12'd2800);  // low
		send_tick(12'd2401);
		send_tick(12'd2400);  // critical
		send_tick(12'd0);
		send_tick(12'd4095);  // back to charging
	endtask

	// full equals empty, empty above full, overlapping thresholds
	task automatic test_percent_span();
		load_config(16'd1, 16'd1000, 16'd1000, 16'd4000, 16'd3800, 16'd2400, 16'd2800);
		send_tick(12'd500);
		send_tick(12'd1500);
		send_tick(12'd1500);
		send_tick(12'd3000);
		// negative divisor: quotient still clamped both ways
		load_config(16'd1, 16'd3000, 16'd1000, 16'd4000, 16'd3800, 16'd2400, 16'd2800);
		send_tick(12'd2000);
		send_tick(12'd2000);
		send_tick(12'd500);
		send_tick(12'd500);
		send_tick(12'd3500);
		send_tick(12'd3500);
		// charging threshold at zero wins over everything
		load_config(16'd0, 16'd0, 16'd4095, 16'd0, 16'd0, 16'd4095, 16'd4095);
		send_tick(12'd1234);
		send_tick(12'd0);
	endtask

	// long interval: run ticks until the next sample comes due
	task automatic test_interval_limit();
		int guard;
		load_config(blm_pkg::CFG_DATA_W'(LONG_INTERVAL), 16'd0, 16'd4095, 16'd4000,
			16'd3800, 16'd2400, 16'd2800);
		quiet = 1'b1;
		guard = 0;
		do begin
			send_tick(blm_pkg::ADC_BITS'($urandom));
			guard++;
		end while (!last_sampled && guard < GUARD_TICKS);
		send_tick(blm_pkg::ADC_BITS'($urandom));
		quiet = 1'b0;
	endtask

	// random register sets, readings clustered near the active thresholds
	task automatic test_random_phases();
		logic [blm_pkg::CFG_DATA_W-1:0] iv, em, fu, ch, ft, cr, lo;
		logic [blm_pkg::ADC_BITS-1:0]   base;
		logic [blm_pkg::ADC_BITS-1:0]   rd;
		for (int p = 0; p < RAND_PHASES; p++) begin
			iv = blm_pkg::CFG_DATA_W'(($urandom_range(0, 3) == 0)
				? $urandom_range(0, 40) : $urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: begin
					em = blm_pkg::CFG_DATA_W'($urandom_range(0, 1000));
					fu = blm_pkg::CFG_DATA_W'($urandom_range(3000, 4095));
				end
				1: begin
					em = blm_pkg::CFG_DATA_W'($urandom_range(0, 4095));
					fu = em;
				end
				2: begin
					fu = blm_pkg::CFG_DATA_W'($urandom_range(0, 2000));
					em = blm_pkg::CFG_DATA_W'($urandom_range(2500, 4095));
				end
				default: begin
					// upper data bits set on purpose, register keeps 12
					em = blm_pkg::CFG_DATA_W'($urandom);
					fu = blm_pkg::CFG_DATA_W'($urandom);
				end
			endcase
			if ($urandom_range(0, 2) != 0) begin
				cr = blm_pkg::CFG_DATA_W'($urandom_range(0, 2000));
				lo = blm_pkg::CFG_DATA_W'(cr + $urandom_range(0, 800));
				ft = blm_pkg::CFG_DATA_W'(lo + $urandom_range(1, 1000));
				ch = blm_pkg::CFG_DATA_W'(ft + $urandom_range(0, 200));
			end else begin
				cr = blm_pkg::CFG_DATA_W'($urandom);
				lo = blm_pkg::CFG_DATA_W'($urandom);
				ft = blm_pkg::CFG_DATA_W'($urandom);
				ch = blm_pkg::CFG_DATA_W'($urandom);
			end
			load_config(iv, em, fu, ch, ft, cr, lo);
			quiet = (p % 3 == 2);
			for (int i = 0; i < PHASE_TICKS; i++) begin
				if ($urandom_range(0, 1) == 0) begin
					rd = blm_pkg::ADC_BITS'($urandom);
				end else begin
					case ($urandom_range(0, 5))
						0:       base = cfg_model.charging_threshold;
						1:       base = cfg_model.full_threshold;
						2:       base = cfg_model.critical_threshold;
						3:       base = cfg_model.low_threshold;
						4:       base = cfg_model.empty_level;
						default: base = cfg_model.full_level;
					endcase
					rd = blm_pkg::ADC_BITS'(int'(base) + $urandom_range(0, 6) - 3);
				end
				send_tick(rd);
			end
			quiet = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		// bench copy starts from the register and state defaults
		cfg_model.interval_ms        = blm_pkg::INTERVAL_W'(blm_pkg::INTERVAL_RST);
		cfg_model.empty_level        = blm_pkg::ADC_BITS'(blm_pkg::EMPTY_RST);
		cfg_model.full_level         = blm_pkg::ADC_BITS'(blm_pkg::FULL_RST);
		cfg_model.charging_threshold = blm_pkg::ADC_BITS'(blm_pkg::CHARGE_RST);
		cfg_model.full_threshold     = blm_pkg::ADC_BITS'(blm_pkg::FULLTH_RST);
		cfg_model.critical_threshold = blm_pkg::ADC_BITS'(blm_pkg::CRIT_RST);
		cfg_model.low_threshold      = blm_pkg::ADC_BITS'(blm_pkg::LOWTH_RST);
		tick_count   = '0;
		first_due    = 1'b1;
		held_reading = '0;
		held_pct     = '0;
		now_state    = blm_pkg::ST_UNKNOWN;
		old_state    = blm_pkg::ST_UNKNOWN;
		last_sampled = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_threshold_sort();
		test_percent_span();
		test_interval_limit();
		test_random_phases();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && tick_results_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
